### rtl/core/plb_pkg.sv
// shared constants and types for the positional list buffer
package plb_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_READ_FWD  = 3'd6,
    OP_READ_BACK = 3'd7
  } plb_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } plb_status_t;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } plb_cell_sel_t;

  typedef struct packed {
    plb_cell_sel_t sel;
  } plb_cell_ctrl_t;

endpackage

### rtl/core/plb_cell.sv
// one storage cell of the shifting chain
module plb_cell
  import plb_pkg::*;
(
  input  logic                      clk,
  input  plb_cell_ctrl_t            ctrl,
  input  logic signed [DATA_W-1:0]  load_data,
  input  logic signed [DATA_W-1:0]  left_data,
  input  logic signed [DATA_W-1:0]  right_data,
  output logic signed [DATA_W-1:0]  data
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    case (ctrl.sel)
      CELL_LOAD:  data_nxt = load_data;
      CELL_LEFT:  data_nxt = left_data;
      CELL_RIGHT: data_nxt = right_data;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

### rtl/core/positional_list_buffer_top.sv
// positional list buffer: ordered store of signed words in a chain of shifting cells
//
// Input channel (in_valid/in_ready) takes one operation per beat: insert at
// front, end or a 1-based position, delete likewise, or read out forward or
// backward. Output channel (out_valid/out_ready) carries status, element, last.
// Inserts and deletes that succeed shift the cells from the target position to
// the tail in the accept cycle and answer one status beat on the next cycle; a
// new insert or delete can be accepted every cycle while the output register
// drains. A read-out rotates the chain by one cell per output beat, emitting
// the front (forward) or tail (backward) cell, and leaves the chain as it found
// it; no input is taken from the accept through the last rotation, and the
// first element reaches the output through the state register and then the
// output register. An empty read-out gives one status beat.
// Reset empties the list (length zero); cell contents are not cleared.
// When the receiver stalls, the output register holds its beat and the block
// stops accepting input / stops rotating until the beat is taken.
module positional_list_buffer_top
  import plb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_op,
  input  logic signed [DATA_W-1:0]  in_value,
  input  logic [POS_W-1:0]          in_position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic signed [DATA_W-1:0]  out_element,
  output logic                      out_last
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                   state_r, state_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [LEN_W-1:0]         cnt_r, cnt_nxt;
  logic                     back_r, back_nxt;
  logic                     out_valid_r, out_valid_nxt;
  plb_status_t              out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_element_r, out_element_nxt;
  logic                     out_last_r, out_last_nxt;

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  plb_cell_ctrl_t           cell_ctrl [CAPACITY];

  logic                     slot_free;
  logic                     in_fire;
  logic                     rd_step;
  logic                     do_ins;
  logic                     do_del;
  logic [CMP_W-1:0]         k_ext;
  logic [CMP_W-1:0]         len_ext;
  logic [CMP_W-1:0]         pos_ext;
  logic [IDX_W-1:0]         tail_idx;
  logic signed [DATA_W-1:0] tail_val;
  logic signed [DATA_W-1:0] load_val;
  logic                     rd_last;
  plb_op_t                  op;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign rd_step   = (state_r == S_READ) && slot_free;
  assign op        = plb_op_t'(in_op);
  assign len_ext   = CMP_W'(len_r);
  assign pos_ext   = CMP_W'(in_position);
  assign tail_idx  = IDX_W'(len_r - LEN_W'(1));
  assign tail_val  = cell_q[tail_idx];
  assign rd_last   = (cnt_r == len_r - LEN_W'(1));
  assign load_val  = do_ins ? in_value : (back_r ? tail_val : cell_q[0]);

  always_comb begin
    state_nxt       = state_r;
    len_nxt         = len_r;
    cnt_nxt         = cnt_r;
    back_nxt        = back_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    do_ins          = 1'b0;
    do_del          = 1'b0;
    k_ext           = '0;

    if (in_fire) begin
      out_element_nxt = '0;
      out_last_nxt    = 1'b1;
      if (op inside {OP_INS_FRONT, OP_INS_END, OP_INS_POS}) begin
        out_valid_nxt = 1'b1;
        if (len_r == LEN_W'(CAPACITY)) begin
          out_status_nxt = ST_FULL;
        end else if (op == OP_INS_POS &&
                     (pos_ext == '0 || pos_ext > len_ext + CMP_W'(1))) begin
          out_status_nxt = ST_RANGE;
        end else begin
          do_ins         = 1'b1;
          len_nxt        = len_r + LEN_W'(1);
          out_status_nxt = ST_OK;
          case (op)
            OP_INS_FRONT: k_ext = '0;
            OP_INS_END:   k_ext = len_ext;
            default:      k_ext = pos_ext - CMP_W'(1);
          endcase
        end
      end else if (op inside {OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS}) begin
        out_valid_nxt = 1'b1;
        if (len_r == '0) begin
          out_status_nxt = ST_EMPTY;
        end else if (op == OP_DEL_POS && (pos_ext == '0 || pos_ext > len_ext)) begin
          out_status_nxt = ST_RANGE;
        end else begin
          do_del         = 1'b1;
          len_nxt        = len_r - LEN_W'(1);
          out_status_nxt = ST_OK;
          case (op)
            OP_DEL_FRONT: k_ext = '0;
            OP_DEL_END:   k_ext = len_ext - CMP_W'(1);
            default:      k_ext = pos_ext - CMP_W'(1);
          endcase
        end
      end else begin
        if (len_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_EMPTY;
        end else begin
          state_nxt = S_READ;
          cnt_nxt   = '0;
          back_nxt  = (op == OP_READ_BACK);
        end
      end
    end

    if (rd_step) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = ST_OK;
      out_element_nxt = back_r ? tail_val : cell_q[0];
      out_last_nxt    = rd_last;
      cnt_nxt         = cnt_r + LEN_W'(1);
      if (rd_last) begin
        state_nxt = S_IDLE;
      end
    end
  end

  // per-cell shift control and the chain itself
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] I = CMP_W'(i);
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    always_comb begin
      cell_ctrl[i].sel = CELL_HOLD;
      if (do_ins) begin
        if (I == k_ext) begin
          cell_ctrl[i].sel = CELL_LOAD;
        end else if (I > k_ext && I <= len_ext) begin
          cell_ctrl[i].sel = CELL_LEFT;
        end
      end else if (do_del) begin
        if (I >= k_ext && I + CMP_W'(1) < len_ext) begin
          cell_ctrl[i].sel = CELL_RIGHT;
        end
      end else if (rd_step && !back_r) begin
        // rotate left, front wraps to the tail
        if (I + CMP_W'(1) < len_ext) begin
          cell_ctrl[i].sel = CELL_RIGHT;
        end else if (I + CMP_W'(1) == len_ext) begin
          cell_ctrl[i].sel = CELL_LOAD;
        end
      end else if (rd_step) begin
        // rotate right, tail wraps to the front
        if (I == '0) begin
          cell_ctrl[i].sel = CELL_LOAD;
        end else if (I < len_ext) begin
          cell_ctrl[i].sel = CELL_LEFT;
        end
      end
    end

    plb_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .load_data  (load_val),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      cnt_r       <= '0;
      back_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      len_r         <= len_nxt;
      cnt_r         <= cnt_nxt;
      back_r        <= back_nxt;
      out_valid_r   <= out_valid_nxt;
      out_status_r  <= out_status_nxt;
      out_element_r <= out_element_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(CAPACITY))
    else $error("length above capacity");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> (len_r != '0 && cnt_r < len_r))
    else $error("read-out running past the list");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_last_r && out_element_r == '0)
    else $error("status beat without last or with element");

  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> len_r == $past(len_r))
    else $error("length changed during read-out");

endmodule
